// File: rtl/lfc_pkg.sv
package lfc_pkg;

    localparam int unsigned PC_W       = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef struct packed {
        logic              operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } lfc_in_t;

    typedef struct packed {
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
    } lfc_out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_FORWARD    = 3'd0,
        REG_GAIN_TURN       = 3'd1,
        REG_LINEAR_LIMIT    = 3'd2,
        REG_ANGULAR_LIMIT   = 3'd3,
        REG_FOLLOW_DISTANCE = 3'd4,
        REG_START_OFFSET_X  = 3'd5,
        REG_START_OFFSET_Y  = 3'd6
    } lfc_reg_idx_t;

    typedef struct packed {
        logic [15:0]        gain_forward;
        logic [15:0]        gain_turn;
        logic [30:0]        linear_limit;
        logic [30:0]        angular_limit;
        logic signed [31:0] follow_distance;
        logic signed [31:0] start_offset_x;
        logic signed [31:0] start_offset_y;
    } lfc_cfg_t;

    typedef enum logic [4:0] {
        OP_NOP      = 5'd0,
        OP_CAPTURE  = 5'd1,
        OP_OFFSET   = 5'd2,
        OP_ERROR    = 5'd3,
        OP_QUAD     = 5'd4,
        OP_TRIG     = 5'd5,
        OP_MUL_CX   = 5'd6,
        OP_MUL_SY   = 5'd7,
        OP_SUM_X    = 5'd8,
        OP_MUL_CY   = 5'd9,
        OP_MUL_SX   = 5'd10,
        OP_DIFF_Y   = 5'd11,
        OP_DIV_INIT = 5'd12,
        OP_DIV_STEP = 5'd13,
        OP_DIV_DONE = 5'd14,
        OP_COPY     = 5'd15,
        OP_GAIN_MUL = 5'd16,
        OP_GAIN_RND = 5'd17,
        OP_CLAMP    = 5'd18,
        OP_LEADER   = 5'd19
    } lfc_op_t;

    typedef enum logic [3:0] {
        COND_NEXT         = 4'd0,
        COND_WAIT_IN      = 4'd1,
        COND_IF_LEADER    = 4'd2,
        COND_IF_NO_LEADER = 4'd3,
        COND_IF_R2_ZERO   = 4'd4,
        COND_LOOP         = 4'd5,
        COND_WAIT_OUT     = 4'd6,
        COND_JUMP         = 4'd7
    } lfc_cond_t;

    typedef struct packed {
        lfc_op_t          op;
        lfc_cond_t        cond;
        logic [PC_W-1:0]  target;
    } lfc_uword_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic is_leader;
        logic leader_seen;
        logic r2_zero;
        logic count_zero;
    } lfc_status_t;

    localparam logic [PC_W-1:0] S_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] S_OFFSET   = 5'd1;
    localparam logic [PC_W-1:0] S_ERROR    = 5'd2;
    localparam logic [PC_W-1:0] S_QUAD     = 5'd3;
    localparam logic [PC_W-1:0] S_TRIG     = 5'd4;
    localparam logic [PC_W-1:0] S_MUL_CX   = 5'd5;
    localparam logic [PC_W-1:0] S_MUL_SY   = 5'd6;
    localparam logic [PC_W-1:0] S_SUM_X    = 5'd7;
    localparam logic [PC_W-1:0] S_MUL_CY   = 5'd8;
    localparam logic [PC_W-1:0] S_MUL_SX   = 5'd9;
    localparam logic [PC_W-1:0] S_DIFF_Y   = 5'd10;
    localparam logic [PC_W-1:0] S_DIV_INIT = 5'd11;
    localparam logic [PC_W-1:0] S_DIV_STEP = 5'd12;
    localparam logic [PC_W-1:0] S_DIV_DONE = 5'd13;
    localparam logic [PC_W-1:0] S_COPY     = 5'd14;
    localparam logic [PC_W-1:0] S_GAIN_MUL = 5'd15;
    localparam logic [PC_W-1:0] S_GAIN_RND = 5'd16;
    localparam logic [PC_W-1:0] S_CLAMP    = 5'd17;
    localparam logic [PC_W-1:0] S_LEADER   = 5'd18;

    function automatic lfc_uword_t ucode(input logic [PC_W-1:0] pc);
        lfc_uword_t w;
        w = '{op: OP_NOP, cond: COND_JUMP, target: S_WAIT};
        case (pc)
            S_WAIT:     w = '{op: OP_CAPTURE,  cond: COND_WAIT_IN,      target: S_WAIT};
            S_OFFSET:   w = '{op: OP_OFFSET,   cond: COND_IF_LEADER,    target: S_LEADER};
            S_ERROR:    w = '{op: OP_ERROR,    cond: COND_IF_NO_LEADER, target: S_WAIT};
            S_QUAD:     w = '{op: OP_QUAD,     cond: COND_NEXT,         target: S_WAIT};
            S_TRIG:     w = '{op: OP_TRIG,     cond: COND_NEXT,         target: S_WAIT};
            S_MUL_CX:   w = '{op: OP_MUL_CX,   cond: COND_IF_R2_ZERO,   target: S_COPY};
            S_MUL_SY:   w = '{op: OP_MUL_SY,   cond: COND_NEXT,         target: S_WAIT};
            S_SUM_X:    w = '{op: OP_SUM_X,    cond: COND_NEXT,         target: S_WAIT};
            S_MUL_CY:   w = '{op: OP_MUL_CY,   cond: COND_NEXT,         target: S_WAIT};
            S_MUL_SX:   w = '{op: OP_MUL_SX,   cond: COND_NEXT,         target: S_WAIT};
            S_DIFF_Y:   w = '{op: OP_DIFF_Y,   cond: COND_NEXT,         target: S_WAIT};
            S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEXT,         target: S_WAIT};
            S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_LOOP,         target: S_WAIT};
            S_DIV_DONE: w = '{op: OP_DIV_DONE, cond: COND_JUMP,         target: S_GAIN_MUL};
            S_COPY:     w = '{op: OP_COPY,     cond: COND_NEXT,         target: S_WAIT};
            S_GAIN_MUL: w = '{op: OP_GAIN_MUL, cond: COND_NEXT,         target: S_WAIT};
            S_GAIN_RND: w = '{op: OP_GAIN_RND, cond: COND_NEXT,         target: S_WAIT};
            S_CLAMP:    w = '{op: OP_CLAMP,    cond: COND_WAIT_OUT,     target: S_WAIT};
            S_LEADER:   w = '{op: OP_LEADER,   cond: COND_JUMP,         target: S_WAIT};
            default:    w = '{op: OP_NOP,      cond: COND_JUMP,         target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/leader_follower_formation_controller_top.sv
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    lfc_in_t   (odometry item)
// m_        out        m_valid / m_ready    lfc_out_t  (velocity commands)
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// one item at a time, driven by a 19-step microprogram over a shared datapath
// leader item: wait, offset and leader steps; own item before any leader: wait, offset and error steps
// own item: runs the 33-step shift-subtract divide loop, or takes the copy step instead if z = w = 0
// synchronous active-low reset clears the program counter, leader state and result valid
// a waiting result holds the program on its final step; input is taken again once it is loaded
module leader_follower_formation_controller_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lfc_pkg::lfc_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lfc_pkg::lfc_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    lfc_pkg::lfc_cfg_t    cfg;
    lfc_pkg::lfc_uword_t  uword;
    lfc_pkg::lfc_status_t status;

    assign cfg_ready = 1'b1;
    assign s_ready   = (uword.cond == lfc_pkg::COND_WAIT_IN);

    lfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .uword   (uword)
    );

    lfc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .uword   (uword),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (status)
    );

    // a result is only ever loaded from the clamp step
    a_result_from_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(uword.op == lfc_pkg::OP_CLAMP))
        else $error("result loaded outside clamp step");

    // after a transaction the program leaves the wait step
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    // a leader transaction never produces a result on its own
    a_leader_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.operation) |=> ##1 (uword.op != lfc_pkg::OP_MUL_CX))
        else $error("leader item entered the command path");

endmodule

// File: rtl/lfc_cfg_regs.sv
module lfc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data,
    output lfc_pkg::lfc_cfg_t              cfg
);

    lfc_pkg::lfc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_forward    <= 16'd256;
            cfg_reg.gain_turn       <= 16'd256;
            cfg_reg.linear_limit    <= 31'd26214;
            cfg_reg.angular_limit   <= 31'd65536;
            cfg_reg.follow_distance <= 32'sd19661;
            cfg_reg.start_offset_x  <= -32'sd52429;
            cfg_reg.start_offset_y  <= 32'sd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lfc_pkg::REG_GAIN_FORWARD:    cfg_reg.gain_forward    <= cfg_data[15:0];
                lfc_pkg::REG_GAIN_TURN:       cfg_reg.gain_turn       <= cfg_data[15:0];
                lfc_pkg::REG_LINEAR_LIMIT:    cfg_reg.linear_limit    <= cfg_data[30:0];
                lfc_pkg::REG_ANGULAR_LIMIT:   cfg_reg.angular_limit   <= cfg_data[30:0];
                lfc_pkg::REG_FOLLOW_DISTANCE: cfg_reg.follow_distance <= $signed(cfg_data);
                lfc_pkg::REG_START_OFFSET_X:  cfg_reg.start_offset_x  <= $signed(cfg_data);
                lfc_pkg::REG_START_OFFSET_Y:  cfg_reg.start_offset_y  <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lfc_sequencer.sv
module lfc_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lfc_pkg::lfc_status_t status,
    output lfc_pkg::lfc_uword_t  uword
);

    logic [lfc_pkg::PC_W-1:0] pc_reg;
    logic [lfc_pkg::PC_W-1:0] pc_next;
    logic [lfc_pkg::PC_W-1:0] pc_inc;

    assign uword  = lfc_pkg::ucode(pc_reg);
    assign pc_inc = pc_reg + lfc_pkg::PC_W'(1);

    always_comb begin
        case (uword.cond)
            lfc_pkg::COND_NEXT:         pc_next = pc_inc;
            lfc_pkg::COND_WAIT_IN:      pc_next = status.in_valid ? pc_inc : pc_reg;
            lfc_pkg::COND_IF_LEADER:    pc_next = status.is_leader ? uword.target : pc_inc;
            lfc_pkg::COND_IF_NO_LEADER: pc_next = status.leader_seen ? pc_inc : uword.target;
            lfc_pkg::COND_IF_R2_ZERO:   pc_next = status.r2_zero ? uword.target : pc_inc;
            lfc_pkg::COND_LOOP:         pc_next = status.count_zero ? pc_inc : pc_reg;
            lfc_pkg::COND_WAIT_OUT:     pc_next = status.out_busy ? pc_reg : uword.target;
            lfc_pkg::COND_JUMP:         pc_next = uword.target;
            default:                    pc_next = lfc_pkg::S_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= lfc_pkg::S_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: rtl/lfc_datapath.sv
module lfc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lfc_pkg::lfc_uword_t  uword,
    input  lfc_pkg::lfc_cfg_t    cfg,
    input  logic                 s_valid,
    input  lfc_pkg::lfc_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lfc_pkg::lfc_out_t    m_data,
    output lfc_pkg::lfc_status_t status
);

    // saturate a 33-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // signed 32-bit value from quotient magnitude and sign, saturating
    function automatic logic signed [31:0] sat_mag(input logic [32:0] q, input logic neg);
        logic [32:0]        nq;
        logic signed [31:0] r;
        nq = 33'd0 - q;
        if (neg) begin
            r = (q > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(nq[31:0]);
        end else begin
            r = (q > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : $signed(q[31:0]);
        end
        return r;
    endfunction

    // divide by 256, round half away from zero
    function automatic logic signed [40:0] rnd256(input logic signed [48:0] p);
        logic [48:0] mag;
        logic [48:0] sum;
        logic [40:0] q;
        mag = p[48] ? 49'(-p) : 49'(p);
        sum = mag + 49'd128;
        q   = sum[48:8];
        return p[48] ? $signed(41'd0 - q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [40:0] v,
                                                 input logic [30:0] lim);
        logic signed [40:0] hi;
        logic signed [40:0] lo;
        logic signed [40:0] r;
        hi = $signed({10'd0, lim});
        lo = -hi;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    lfc_pkg::lfc_in_t   in_reg;
    logic signed [31:0] leader_x_reg, leader_y_reg;
    logic               leader_seen_reg;
    logic signed [31:0] sx_reg, sy_reg, tx_reg;
    logic signed [31:0] ex_reg, ey_reg;
    logic [30:0]        ww_reg, zz_reg;
    logic signed [31:0] zw_reg;
    logic signed [31:0] c_reg;
    logic signed [32:0] s_reg;
    logic [31:0]        r2_reg;
    logic signed [64:0] prod_reg, acc_reg, numx_reg, numy_reg;
    logic [31:0]        remx_reg, remy_reg;
    logic [32:0]        qx_reg, qy_reg;
    logic               negx_reg, negy_reg;
    logic [5:0]         cnt_reg;
    logic signed [31:0] bx_reg, by_reg;
    logic signed [48:0] pv_reg, pw_reg;
    logic signed [40:0] rv_reg, rw_reg;
    lfc_pkg::lfc_out_t  out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               in_fire;
    logic               out_busy;
    logic               out_load;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [31:0] ww_full, zz_full, zw_full;
    logic [64:0]        magx, magy;
    logic [62:0]        nx, ny;
    logic [32:0]        tx_step, ty_step;
    logic               gex, gey;

    assign in_fire  = (uword.cond == lfc_pkg::COND_WAIT_IN) && s_valid;
    assign out_busy = out_valid_reg && !m_ready;
    assign out_load = (uword.op == lfc_pkg::OP_CLAMP) && !out_busy;

    assign status.in_valid    = s_valid;
    assign status.out_busy    = out_busy;
    assign status.is_leader   = in_reg.operation;
    assign status.leader_seen = leader_seen_reg;
    assign status.r2_zero     = (r2_reg == 32'd0);
    assign status.count_zero  = (cnt_reg == 6'd0);

    // shared product unit
    always_comb begin
        case (uword.op)
            lfc_pkg::OP_MUL_CX: begin
                mul_a = 33'(c_reg);
                mul_b = ex_reg;
            end
            lfc_pkg::OP_MUL_SY: begin
                mul_a = s_reg;
                mul_b = ey_reg;
            end
            lfc_pkg::OP_MUL_CY: begin
                mul_a = 33'(c_reg);
                mul_b = ey_reg;
            end
            default: begin
                mul_a = s_reg;
                mul_b = ex_reg;
            end
        endcase
    end

    assign mul_p   = 65'(mul_a) * 65'(mul_b);
    assign ww_full = 32'(in_reg.quat_w) * 32'(in_reg.quat_w);
    assign zz_full = 32'(in_reg.quat_z) * 32'(in_reg.quat_z);
    assign zw_full = 32'(in_reg.quat_z) * 32'(in_reg.quat_w);

    assign magx = numx_reg[64] ? 65'(-numx_reg) : 65'(numx_reg);
    assign magy = numy_reg[64] ? 65'(-numy_reg) : 65'(numy_reg);
    assign nx   = magx[62:0] + 63'(r2_reg[31:1]);
    assign ny   = magy[62:0] + 63'(r2_reg[31:1]);

    assign tx_step = {remx_reg, qx_reg[32]};
    assign ty_step = {remy_reg, qy_reg[32]};
    assign gex     = tx_step >= {1'b0, r2_reg};
    assign gey     = ty_step >= {1'b0, r2_reg};

    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leader_seen_reg <= 1'b0;
            leader_x_reg    <= 32'sd0;
            leader_y_reg    <= 32'sd0;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (uword.op == lfc_pkg::OP_LEADER) begin
                leader_seen_reg <= 1'b1;
                leader_x_reg    <= in_reg.pos_x;
                leader_y_reg    <= in_reg.pos_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.linear_velocity  <= clamp(rv_reg, cfg.linear_limit);
            out_reg.angular_velocity <= clamp(rw_reg, cfg.angular_limit);
        end
        case (uword.op)
            lfc_pkg::OP_CAPTURE: begin
                if (in_fire) begin
                    in_reg <= s_data;
                end
            end
            lfc_pkg::OP_OFFSET: begin
                sx_reg <= sat33(33'(in_reg.pos_x) + 33'(cfg.start_offset_x));
                sy_reg <= sat33(33'(in_reg.pos_y) + 33'(cfg.start_offset_y));
                tx_reg <= sat33(33'(leader_x_reg) - 33'(cfg.follow_distance));
            end
            lfc_pkg::OP_ERROR: begin
                ex_reg <= sat33(33'(tx_reg) - 33'(sx_reg));
                ey_reg <= sat33(33'(leader_y_reg) - 33'(sy_reg));
            end
            lfc_pkg::OP_QUAD: begin
                ww_reg <= ww_full[30:0];
                zz_reg <= zz_full[30:0];
                zw_reg <= zw_full;
            end
            lfc_pkg::OP_TRIG: begin
                c_reg  <= $signed({1'b0, ww_reg}) - $signed({1'b0, zz_reg});
                s_reg  <= $signed({zw_reg, 1'b0});
                r2_reg <= {1'b0, ww_reg} + {1'b0, zz_reg};
            end
            lfc_pkg::OP_MUL_CX, lfc_pkg::OP_MUL_CY: begin
                prod_reg <= mul_p;
            end
            lfc_pkg::OP_MUL_SY, lfc_pkg::OP_MUL_SX: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            lfc_pkg::OP_SUM_X: begin
                numx_reg <= acc_reg + prod_reg;
            end
            lfc_pkg::OP_DIFF_Y: begin
                numy_reg <= acc_reg - prod_reg;
            end
            lfc_pkg::OP_DIV_INIT: begin
                remx_reg <= {2'b00, nx[62:33]};
                remy_reg <= {2'b00, ny[62:33]};
                qx_reg   <= nx[32:0];
                qy_reg   <= ny[32:0];
                negx_reg <= numx_reg[64];
                negy_reg <= numy_reg[64];
                cnt_reg  <= 6'd32;
            end
            lfc_pkg::OP_DIV_STEP: begin
                remx_reg <= gex ? 32'(tx_step - {1'b0, r2_reg}) : tx_step[31:0];
                remy_reg <= gey ? 32'(ty_step - {1'b0, r2_reg}) : ty_step[31:0];
                qx_reg   <= {qx_reg[31:0], gex};
                qy_reg   <= {qy_reg[31:0], gey};
                if (cnt_reg != 6'd0) begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            lfc_pkg::OP_DIV_DONE: begin
                bx_reg <= sat_mag(qx_reg, negx_reg);
                by_reg <= sat_mag(qy_reg, negy_reg);
            end
            lfc_pkg::OP_COPY: begin
                bx_reg <= ex_reg;
                by_reg <= ey_reg;
            end
            lfc_pkg::OP_GAIN_MUL: begin
                pv_reg <= 49'(bx_reg) * 49'($signed({1'b0, cfg.gain_forward}));
                pw_reg <= 49'(by_reg) * 49'($signed({1'b0, cfg.gain_turn}));
            end
            lfc_pkg::OP_GAIN_RND: begin
                rv_reg <= rnd256(pv_reg);
                rw_reg <= rnd256(pw_reg);
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: bench/lfc_tb_pkg.sv
package lfc_tb_pkg;

    localparam logic ODOM_OWN    = 1'b0;
    localparam logic ODOM_LEADER = 1'b1;

    // index with no register behind it
    localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

endpackage

// File: bench/lfc_command_checker.sv
module lfc_command_checker
    import lfc_pkg::*;
    import lfc_tb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  lfc_in_t                 s_data,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  lfc_out_t                m_data,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      errors,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    lfc_cfg_t   cfg_shadow;
    longint     leader_px;
    longint     leader_py;
    bit         leader_known;
    lfc_out_t   expected_cmds[$];
    lfc_out_t   want;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // nearest, ties away from zero
    function automatic longint round_quot(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic lfc_out_t predict_commands(lfc_in_t odo);
        longint sx, sy, tx, ty, ex, ey;
        longint zq, wq, c, s, r2, bx, by;
        longint g_fwd, g_turn, lim_lin, lim_ang, v, om;
        lfc_out_t cmd;
        zq = odo.quat_z;
        wq = odo.quat_w;
        g_fwd = cfg_shadow.gain_forward;
        g_turn = cfg_shadow.gain_turn;
        lim_lin = cfg_shadow.linear_limit;
        lim_ang = cfg_shadow.angular_limit;
        sx = clip32(longint'(odo.pos_x) + longint'(cfg_shadow.start_offset_x));
        sy = clip32(longint'(odo.pos_y) + longint'(cfg_shadow.start_offset_y));
        tx = clip32(leader_px - longint'(cfg_shadow.follow_distance));
        ty = leader_py;
        ex = clip32(tx - sx);
        ey = clip32(ty - sy);
        c = wq * wq - zq * zq;
        s = 2 * zq * wq;
        r2 = wq * wq + zq * zq;
        if (r2 == 0) begin
            bx = ex;
            by = ey;
        end else begin
            bx = clip32(round_quot(c * ex + s * ey, r2));
            by = clip32(round_quot(c * ey - s * ex, r2));
        end
        v = clamp_to(round_quot(bx * g_fwd, 256), lim_lin);
        om = clamp_to(round_quot(by * g_turn, 256), lim_ang);
        cmd.linear_velocity = v[31:0];
        cmd.angular_velocity = om[31:0];
        return cmd;
    endfunction

    task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_FORWARD:    cfg_shadow.gain_forward = data[15:0];
            REG_GAIN_TURN:       cfg_shadow.gain_turn = data[15:0];
            REG_LINEAR_LIMIT:    cfg_shadow.linear_limit = data[30:0];
            REG_ANGULAR_LIMIT:   cfg_shadow.angular_limit = data[30:0];
            REG_FOLLOW_DISTANCE: cfg_shadow.follow_distance = data;
            REG_START_OFFSET_X:  cfg_shadow.start_offset_x = data;
            REG_START_OFFSET_Y:  cfg_shadow.start_offset_y = data;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint exp_val);
        $display("[%0t] mismatch: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_shadow.gain_forward = 16'd256;
            cfg_shadow.gain_turn = 16'd256;
            cfg_shadow.linear_limit = 31'd26214;
            cfg_shadow.angular_limit = 31'd65536;
            cfg_shadow.follow_distance = 32'sd19661;
            cfg_shadow.start_offset_x = -32'sd52429;
            cfg_shadow.start_offset_y = 32'sd0;
            leader_px = 0;
            leader_py = 0;
            leader_known = 1'b0;
            expected_cmds.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
            end
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("result transaction with nothing expected, linear",
                                    m_data.linear_velocity, 0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_data.linear_velocity !== want.linear_velocity)
                        report_mismatch("linear_velocity", m_data.linear_velocity,
                                        want.linear_velocity);
                    if (m_data.angular_velocity !== want.angular_velocity)
                        report_mismatch("angular_velocity", m_data.angular_velocity,
                                        want.angular_velocity);
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.operation == ODOM_LEADER) begin
                    leader_px = s_data.pos_x;
                    leader_py = s_data.pos_y;
                    leader_known = 1'b1;
                end else if (leader_known) begin
                    expected_cmds.push_back(predict_commands(s_data));
                end
            end
        end
        outstanding = expected_cmds.size();
    end

endmodule

// File: bench/tb_leader_follower_formation_controller_top.sv
module tb_leader_follower_formation_controller_top;
    import lfc_pkg::*;
    import lfc_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 120;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    lfc_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    lfc_out_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     outstanding;
    int                     burst_left;
    int unsigned            quiet_cycles;

    leader_follower_formation_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfc_command_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side stalls on a pattern of its own
    initial begin
        rx_mode_e mode;
        int span;
        m_ready = 1'b0;
        forever begin
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
            for (int k = 0; k < span; k++) begin
                @(negedge aclk);
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ((k % 16) >= 11);
                endcase
            end
        end
    end

    function automatic lfc_in_t odometry(logic op, logic [31:0] x, logic [31:0] y,
                                         logic [15:0] z, logic [15:0] w);
        lfc_in_t item;
        item.operation = op;
        item.pos_x = x;
        item.pos_y = y;
        item.quat_z = z;
        item.quat_w = w;
        return item;
    endfunction

    function automatic logic [31:0] random_position();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return 32'($signed($urandom()) >>> $urandom_range(4, 16));
        endcase
    endfunction

    function automatic logic [15:0] random_quat_part();
        case ($urandom_range(0, 9))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic lfc_in_t random_odometry();
        logic [15:0] z;
        logic [15:0] w;
        z = random_quat_part();
        w = random_quat_part();
        if ($urandom_range(0, 24) == 0) begin
            z = '0;
            w = '0;
        end
        return odometry(($urandom_range(0, 3) == 0) ? ODOM_LEADER : ODOM_OWN,
                        random_position(), random_position(), z, w);
    endfunction

    task automatic send_odometry(lfc_in_t item);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain(bit settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [31:0] g_fwd, logic [31:0] g_turn, logic [31:0] lim_lin,
                             logic [31:0] lim_ang, logic [31:0] follow,
                             logic [31:0] off_x, logic [31:0] off_y);
        write_reg(REG_GAIN_FORWARD, g_fwd);
        write_reg(REG_GAIN_TURN, g_turn);
        write_reg(REG_LINEAR_LIMIT, lim_lin);
        write_reg(REG_ANGULAR_LIMIT, lim_ang);
        write_reg(REG_FOLLOW_DISTANCE, follow);
        write_reg(REG_START_OFFSET_X, off_x);
        write_reg(REG_START_OFFSET_Y, off_y);
    endtask

    task automatic run_phase(int count);
        repeat (count) begin
            send_odometry(random_odometry());
            pace();
            if ($urandom_range(0, 99) == 0) drain(1'b0);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // own poses before any leader give nothing
        send_odometry(odometry(ODOM_OWN, 32'd100, 32'd200, 16'sd0, 16'sd16384));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'd5, 32'd7, 16'sd0, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_LEADER, 32'd0, 32'd0, 16'sd0, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'd0, 32'd0, 16'sd0, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'sd65536, -32'sd65536, 16'sd0, 16'sd16384));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'sd65536, 32'sd65536, 16'sd16384, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, -32'sd200000, 32'sd300000, 16'sd16384, 16'sd16384));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'sd12345, -32'sd54321, -16'sd16384, 16'sd16384));
        pace();
        // unnormalised quaternions
        send_odometry(odometry(ODOM_OWN, 32'sd1000, 32'sd1000, 16'sd3, 16'sd4));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'sd1000, -32'sd1000, 16'sd0, -16'sd1));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'sd70000, 32'sd9000, -16'sd16384, -16'sd16384));
        pace();
        // saturating sums and differences
        send_odometry(odometry(ODOM_LEADER, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd1, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, -16'sd16384));
        pace();
        send_odometry(odometry(ODOM_LEADER, 32'h8000_0000, 32'h7FFF_FFFF,
                               -16'sd16384, 16'sd16384));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'h8000_0000, 32'h8000_0000, -16'sd16384, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_LEADER, 32'sd327680, -32'sd196608, 16'sd0, 16'sd0));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'sd65536, 32'sd0, 16'sd0, 16'sd16384));
        pace();
        send_odometry(odometry(ODOM_OWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd12000, -16'sd9000));
        pace();
        send_odometry(odometry(ODOM_LEADER, 32'hFFFF_FFFF, 32'sd1, 16'sd0, 16'sd0));
        send_odometry(odometry(ODOM_LEADER, 32'sd131072, 32'sd131072, 16'sd0, 16'sd0));
        pace();

        run_phase(PHASE_ITEMS);

        // top of each range (start x offset at its bottom), masked bits set on forward gain and linear limit
        drain(1'b1);
        configure(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_reg(REG_UNMAPPED, $urandom());
        run_phase(PHASE_ITEMS);

        drain(1'b1);
        configure(32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000);
        run_phase(PHASE_ITEMS);

        repeat (3) begin
            drain(1'b1);
            configure(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(64, 1024),
                      ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(64, 1024),
                      ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 1 << 20),
                      ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 1 << 20),
                      random_position(), random_position(), random_position());
            if ($urandom_range(0, 1) == 0) write_reg(REG_UNMAPPED, $urandom());
            run_phase(PHASE_ITEMS);
        end

        drain(1'b1);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
